FILE: sv/checked_frame_odometry_receiver_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the checked frame odometry receiver
// Both macros expect signals named clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef CHECKED_FRAME_ODOMETRY_RECEIVER_MACROS_SVH
`define CHECKED_FRAME_ODOMETRY_RECEIVER_MACROS_SVH

// same-cycle implication
`define CFOR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CFOR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/cfor_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfor_pkg
// Shared widths, codes and frame layout constants of the odometry receiver.
// ----------------------------------------------------------------------------
package cfor_pkg;

  localparam int FRAME_LEN = 9;
  localparam int IDX_W     = 4;
  localparam int BYTE_W    = 8;
  localparam int DELTA_W   = 16;
  localparam int TOTAL_W   = 32;
  localparam int ERR_W     = 16;
  localparam int SEL_W     = 2;

  // index of the checksum byte
  localparam logic [IDX_W-1:0] SUM_POS = IDX_W'(FRAME_LEN - 1);
  localparam logic [IDX_W-1:0] IDX_IDLE = '0;
  localparam logic [ERR_W-1:0] ERR_MAX  = '1;

  localparam logic OP_BYTE   = 1'b0;
  localparam logic OP_PRESET = 1'b1;

endpackage

FILE: sv/cfor_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfor channel interfaces
// Valid/ready channels for incoming words and finished frame reports.
// ----------------------------------------------------------------------------
interface cfor_in_if;
  import cfor_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic                       source;
  logic                       frame_start;
  logic [BYTE_W-1:0]          data_byte;
  logic [SEL_W-1:0]           encoder_select;
  logic signed [TOTAL_W-1:0]  preset_value;

  modport source_mp (output valid, operation, source, frame_start, data_byte,
                     encoder_select, preset_value, input ready);
  modport sink (input valid, operation, source, frame_start, data_byte,
                encoder_select, preset_value, output ready);
endinterface

interface cfor_out_if;
  import cfor_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       frame_ok;
  logic                       frame_source;
  logic signed [DELTA_W-1:0]  delta_first;
  logic signed [DELTA_W-1:0]  delta_second;
  logic [BYTE_W-1:0]          analog_0;
  logic [BYTE_W-1:0]          analog_1;
  logic [BYTE_W-1:0]          analog_2;
  logic [BYTE_W-1:0]          analog_3;
  logic signed [TOTAL_W-1:0]  total_first;
  logic signed [TOTAL_W-1:0]  total_second;
  logic [ERR_W-1:0]           error_count;

  modport source_mp (output valid, frame_ok, frame_source, delta_first, delta_second,
                     analog_0, analog_1, analog_2, analog_3, total_first,
                     total_second, error_count, input ready);
  modport sink (input valid, frame_ok, frame_source, delta_first, delta_second,
                analog_0, analog_1, analog_2, analog_3, total_first,
                total_second, error_count, output ready);
endinterface

FILE: sv/checked_frame_odometry_receiver.sv
`timescale 1ns / 1ps
// Path: a checksum word is held in the input register, then its report in the result
//   register; a report not yet taken stalls the input register.
// Throughput: one word per cycle unless stalled; one pass from input to result register.
// Reset (rst_n low, synchronous): byte counter idle, totals, error counters and
//   source cleared; both pipeline registers emptied.
// ----------------------------------------------------------------------------
// checked_frame_odometry_receiver
// Assembles 9-byte encoder frames from two slave boards, checks the additive
// checksum, accumulates position totals and counts frame errors.
// ----------------------------------------------------------------------------
module checked_frame_odometry_receiver (
  input  logic            clk,
  input  logic            rst_n,
  cfor_in_if.sink         in_ch,
  cfor_out_if.source_mp   out_ch
);
  import cfor_pkg::*;

  `include "checked_frame_odometry_receiver_macros.svh"

  // input register
  logic                       s1_valid_r;
  logic                       s1_op_r;
  logic                       s1_src_r;
  logic                       s1_start_r;
  logic [BYTE_W-1:0]          s1_byte_r;
  logic [SEL_W-1:0]           s1_sel_r;
  logic [TOTAL_W-1:0]         s1_pval_r;

  // frame state
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic [BYTE_W-1:0]          sum_r, sum_nxt;
  logic                       cur_src_r, cur_src_nxt;
  logic [BYTE_W-1:0]          fbytes_r [8];
  logic [TOTAL_W-1:0]         tot_first_r [2];
  logic [TOTAL_W-1:0]         tot_second_r [2];
  logic [ERR_W-1:0]           err_cnt_r [2];

  // result register
  logic                       out_valid_r;
  logic                       out_ok_r;
  logic                       out_src_r;
  logic [DELTA_W-1:0]         out_d1_r, out_d2_r;
  logic [BYTE_W-1:0]          out_an_r [4];
  logic [TOTAL_W-1:0]         out_tot1_r, out_tot2_r;
  logic [ERR_W-1:0]           out_err_r;

  logic                       s1_go;
  logic                       in_acc;
  logic                       is_byte, is_preset;
  logic                       do_start, do_store, do_done;
  logic                       sum_ok;
  logic                       err_inc;
  logic                       err_slave;
  logic [ERR_W-1:0]           err_sel, err_new;
  logic [DELTA_W-1:0]         d1, d2;
  logic [TOTAL_W-1:0]         tot1_new, tot2_new;

  assign s1_go   = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_acc  = in_ch.valid && in_ch.ready;

  assign is_preset = s1_go && (s1_op_r == OP_PRESET);
  assign is_byte   = s1_go && (s1_op_r == OP_BYTE);
  assign do_start  = is_byte && s1_start_r;
  assign do_store  = is_byte && !s1_start_r && (idx_r != IDX_IDLE) && (idx_r < SUM_POS);
  assign do_done   = is_byte && !s1_start_r && (idx_r == SUM_POS);

  assign sum_ok = (sum_r == s1_byte_r);
  assign d1 = {fbytes_r[0], fbytes_r[1]};
  assign d2 = {fbytes_r[2], fbytes_r[3]};
  assign tot1_new = tot_first_r[cur_src_r] + {{(TOTAL_W-DELTA_W){d1[DELTA_W-1]}}, d1};
  assign tot2_new = tot_second_r[cur_src_r] + {{(TOTAL_W-DELTA_W){d2[DELTA_W-1]}}, d2};

  // cut-short frame or bad checksum both charge the frame's own slave
  assign err_inc   = (do_start && (idx_r != IDX_IDLE)) || (do_done && !sum_ok);
  assign err_slave = cur_src_r;
  assign err_sel   = err_cnt_r[err_slave];
  assign err_new   = (err_inc && (err_sel != ERR_MAX)) ? err_sel + ERR_W'(1) : err_sel;

  always_comb begin
    idx_nxt     = idx_r;
    sum_nxt     = sum_r;
    cur_src_nxt = cur_src_r;
    if (do_start) begin
      idx_nxt     = IDX_W'(1);
      sum_nxt     = s1_byte_r;
      cur_src_nxt = s1_src_r;
    end else if (do_store) begin
      idx_nxt = idx_r + IDX_W'(1);
      sum_nxt = sum_r + s1_byte_r;
    end else if (do_done) begin
      idx_nxt = IDX_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= in_ch.operation;
      s1_src_r   <= in_ch.source;
      s1_start_r <= in_ch.frame_start;
      s1_byte_r  <= in_ch.data_byte;
      s1_sel_r   <= in_ch.encoder_select;
      s1_pval_r  <= in_ch.preset_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= IDX_IDLE;
      sum_r     <= '0;
      cur_src_r <= 1'b0;
    end else begin
      idx_r     <= idx_nxt;
      sum_r     <= sum_nxt;
      cur_src_r <= cur_src_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_start) begin
      fbytes_r[0] <= s1_byte_r;
    end else if (do_store) begin
      fbytes_r[idx_r[2:0]] <= s1_byte_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_first_r[0]  <= '0;
      tot_first_r[1]  <= '0;
      tot_second_r[0] <= '0;
      tot_second_r[1] <= '0;
      err_cnt_r[0]    <= '0;
      err_cnt_r[1]    <= '0;
    end else begin
      if (is_preset) begin
        // select: upper bit picks the slave, lower bit first or second encoder
        if (s1_sel_r[0]) begin
          tot_second_r[s1_sel_r[1]] <= s1_pval_r;
        end else begin
          tot_first_r[s1_sel_r[1]] <= s1_pval_r;
        end
      end else if (do_done && sum_ok) begin
        tot_first_r[cur_src_r]  <= tot1_new;
        tot_second_r[cur_src_r] <= tot2_new;
      end
      if (err_inc) begin
        err_cnt_r[err_slave] <= err_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_done) begin
      out_ok_r  <= sum_ok;
      out_src_r <= cur_src_r;
      out_d1_r  <= sum_ok ? d1 : '0;
      out_d2_r  <= sum_ok ? d2 : '0;
      for (int i = 0; i < 4; i++) begin
        out_an_r[i] <= sum_ok ? fbytes_r[4 + i] : '0;
      end
      out_tot1_r <= sum_ok ? tot1_new : tot_first_r[cur_src_r];
      out_tot2_r <= sum_ok ? tot2_new : tot_second_r[cur_src_r];
      out_err_r  <= err_new;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.frame_ok     = out_ok_r;
  assign out_ch.frame_source = out_src_r;
  assign out_ch.delta_first  = out_d1_r;
  assign out_ch.delta_second = out_d2_r;
  assign out_ch.analog_0     = out_an_r[0];
  assign out_ch.analog_1     = out_an_r[1];
  assign out_ch.analog_2     = out_an_r[2];
  assign out_ch.analog_3     = out_an_r[3];
  assign out_ch.total_first  = out_tot1_r;
  assign out_ch.total_second = out_tot2_r;
  assign out_ch.error_count  = out_err_r;

  `CFOR_ASSERT_IMP(a_bad_frame_zeroed, out_valid_r && !out_ok_r, (out_d1_r == '0) && (out_d2_r == '0) && (out_an_r[0] == '0) && (out_an_r[3] == '0), "bad frame report carries data")
  `CFOR_ASSERT_IMP(a_idx_range, 1'b1, idx_r <= SUM_POS, "byte counter past checksum position")
  `CFOR_ASSERT_NXT(a_err_monotonic, 1'b1, (err_cnt_r[0] >= $past(err_cnt_r[0])) && (err_cnt_r[1] >= $past(err_cnt_r[1])), "error counter decreased")
  `CFOR_ASSERT_IMP(a_empty_stage_ready, !s1_valid_r, in_ch.ready, "empty input stage refuses a word")

endmodule
